FILE: sv/csvfs_pkg.sv
`timescale 1ns / 1ps
// csvfs_pkg: item types, result kinds, error codes and register map
// for the csv field splitter; no dependencies

package csvfs_pkg;

    // input item: one text byte or the end-of-stream mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } csv_in_t;

    // result item
    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       stream_done;
    } csv_out_t;

    // result kinds
    localparam logic [2:0] KIND_BYTE       = 3'd0;
    localparam logic [2:0] KIND_FIELD_END  = 3'd1;
    localparam logic [2:0] KIND_LINE_END   = 3'd2;
    localparam logic [2:0] KIND_EMPTY      = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;
    localparam logic [2:0] KIND_STREAM_END = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_LINE_LONG  = 2'd1;
    localparam logic [1:0] ERR_COLUMNS    = 2'd2;
    localparam logic [1:0] ERR_OPEN_QUOTE = 2'd3;

    // control bytes
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    // register map (word index)
    localparam int          REG_ADDR_BITS  = 4;
    localparam logic [1:0]  REG_SEPARATOR  = 2'd0;
    localparam logic [1:0]  REG_QUOTE      = 2'd1;
    localparam logic [1:0]  REG_LINE_LIMIT = 2'd2;
    localparam logic [1:0]  REG_COL_LIMIT  = 2'd3;

    // register widths and reset values
    localparam int          LINE_LIMIT_BITS = 20;
    localparam int          COL_LIMIT_BITS  = 16;
    localparam logic [7:0]  SEPARATOR_RST   = 8'd44;
    localparam logic [7:0]  QUOTE_RST       = 8'd34;
    localparam logic [LINE_LIMIT_BITS-1:0] LINE_LIMIT_RST = 20'd1048575;
    localparam logic [COL_LIMIT_BITS-1:0]  COL_LIMIT_RST  = 16'd65535;

endpackage

FILE: sv/csv_field_splitter.sv
`timescale 1ns / 1ps
// csv_field_splitter: splits a byte stream into lines and fields, with quoting,
// limits and error skipping; depends on csvfs_pkg
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_ready    csv_in_t  (byte or end mark)
//  result    out        result_valid / result_ready csv_out_t (kind, byte, code)
//  config    in         psel / penable / pready    32-bit APB registers 0..3
//
// One item per cycle sustained while results are taken: an input register feeds
// one level of parse logic that writes the result register.
// The stage advances whenever the result register is empty or being taken.
// A stalled result side holds the stage; the input register still takes one item.
// Reset restores register defaults and clears all line state; no clearing pass.

module csv_field_splitter #(
    parameter int LINE_COUNT_BITS  = 20,
    parameter int FIELD_COUNT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item input
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  csvfs_pkg::csv_in_t                    item,
    // result output
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output csvfs_pkg::csv_out_t                   result,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [csvfs_pkg::REG_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    import csvfs_pkg::*;

    localparam int LW = (LINE_COUNT_BITS > LINE_LIMIT_BITS) ? LINE_COUNT_BITS
                                                            : LINE_LIMIT_BITS;
    localparam int CW = (FIELD_COUNT_BITS + 1 > COL_LIMIT_BITS) ? FIELD_COUNT_BITS + 1
                                                                : COL_LIMIT_BITS;

    // configuration registers
    logic [7:0]                 separator_reg;
    logic [7:0]                 quote_reg;
    logic [LINE_LIMIT_BITS-1:0] line_limit_reg;
    logic [COL_LIMIT_BITS-1:0]  col_limit_reg;

    // pipeline registers
    logic     in_valid_reg;
    csv_in_t  in_item_reg;
    logic     out_valid_reg;
    csv_out_t out_item_reg;

    // line state
    logic                        in_quotes_reg,   in_quotes_next;
    logic                        quote_pend_reg,  quote_pend_next;
    logic                        field_start_reg, field_start_next;
    logic                        skip_reg,        skip_next;
    logic [LINE_COUNT_BITS-1:0]  line_count_reg,  line_count_next;
    logic [FIELD_COUNT_BITS-1:0] field_count_reg, field_count_next;

    logic     has_result;
    csv_out_t out_item_next;
    logic     fire;
    logic     cfg_write;
    logic     line_full;
    logic     col_full;
    logic     in_quotes_eff;
    logic [LINE_COUNT_BITS-1:0]  line_count_inc;
    logic [FIELD_COUNT_BITS-1:0] field_count_inc;
    logic [7:0] b;

    // handshake
    assign fire         = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || fire;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[REG_ADDR_BITS-1:2])
            REG_SEPARATOR:  prdata = {24'd0, separator_reg};
            REG_QUOTE:      prdata = {24'd0, quote_reg};
            REG_LINE_LIMIT: prdata = {{(32-LINE_LIMIT_BITS){1'b0}}, line_limit_reg};
            REG_COL_LIMIT:  prdata = {{(32-COL_LIMIT_BITS){1'b0}}, col_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg  <= SEPARATOR_RST;
            quote_reg      <= QUOTE_RST;
            line_limit_reg <= LINE_LIMIT_RST;
            col_limit_reg  <= COL_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[REG_ADDR_BITS-1:2])
                REG_SEPARATOR:  separator_reg  <= pwdata[7:0];
                REG_QUOTE:      quote_reg      <= pwdata[7:0];
                REG_LINE_LIMIT: line_limit_reg <= pwdata[LINE_LIMIT_BITS-1:0];
                REG_COL_LIMIT:  col_limit_reg  <= pwdata[COL_LIMIT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // limit checks; counters saturate at their own width as a second limit
    assign b               = in_item_reg.in_byte;
    assign line_count_inc  = line_count_reg + 1'b1;
    assign field_count_inc = field_count_reg + 1'b1;
    assign line_full = (LW'(line_count_reg) >= LW'(line_limit_reg))
                       || (line_count_reg == {LINE_COUNT_BITS{1'b1}});
    assign col_full  = (CW'(field_count_inc) >= CW'(col_limit_reg))
                       || (field_count_inc == {FIELD_COUNT_BITS{1'b1}});

    // parse decision for the item in the input register
    always_comb
    begin
        in_quotes_next   = in_quotes_reg;
        quote_pend_next  = quote_pend_reg;
        field_start_next = field_start_reg;
        skip_next        = skip_reg;
        line_count_next  = line_count_reg;
        field_count_next = field_count_reg;
        has_result       = 1'b0;
        out_item_next    = '0;
        in_quotes_eff    = in_quotes_reg;

        if (in_item_reg.end_of_input)
        begin
            has_result                = 1'b1;
            out_item_next.stream_done = 1'b1;
            if (skip_reg)
                out_item_next.out_kind = KIND_STREAM_END;
            else if (in_quotes_reg && !quote_pend_reg)
            begin
                out_item_next.out_kind   = KIND_ERROR;
                out_item_next.error_code = ERR_OPEN_QUOTE;
            end
            else if (line_count_reg == '0)
                out_item_next.out_kind = KIND_STREAM_END;
            else
                out_item_next.out_kind = KIND_LINE_END;
            in_quotes_next   = 1'b0;
            quote_pend_next  = 1'b0;
            field_start_next = 1'b1;
            skip_next        = 1'b0;
            line_count_next  = '0;
            field_count_next = '0;
        end
        else if (skip_reg)
        begin
            // drop bytes up to and including the newline
            if (b == CH_LF)
            begin
                in_quotes_next   = 1'b0;
                quote_pend_next  = 1'b0;
                field_start_next = 1'b1;
                skip_next        = 1'b0;
                line_count_next  = '0;
                field_count_next = '0;
            end
        end
        else if (quote_pend_reg && (b == quote_reg))
        begin
            // doubled quote is one content byte
            quote_pend_next = 1'b0;
            has_result      = 1'b1;
            if (line_full)
            begin
                skip_next                = 1'b1;
                out_item_next.out_kind   = KIND_ERROR;
                out_item_next.error_code = ERR_LINE_LONG;
            end
            else
            begin
                line_count_next        = line_count_inc;
                out_item_next.out_kind = KIND_BYTE;
                out_item_next.out_byte = b;
            end
        end
        else
        begin
            // a pending quote followed by anything else closes the quoted text
            if (quote_pend_reg)
            begin
                quote_pend_next = 1'b0;
                in_quotes_next  = 1'b0;
                in_quotes_eff   = 1'b0;
            end

            if (b == CH_CR)
            begin
                // carriage returns are dropped
            end
            else if (b == CH_LF)
            begin
                has_result = 1'b1;
                if (in_quotes_eff)
                begin
                    out_item_next.out_kind   = KIND_ERROR;
                    out_item_next.error_code = ERR_OPEN_QUOTE;
                end
                else if (line_count_reg == '0)
                    out_item_next.out_kind = KIND_EMPTY;
                else
                    out_item_next.out_kind = KIND_LINE_END;
                in_quotes_next   = 1'b0;
                quote_pend_next  = 1'b0;
                field_start_next = 1'b1;
                skip_next        = 1'b0;
                line_count_next  = '0;
                field_count_next = '0;
            end
            else if (in_quotes_eff)
            begin
                if (b == quote_reg)
                    quote_pend_next = 1'b1;
                else
                begin
                    has_result = 1'b1;
                    if (line_full)
                    begin
                        skip_next                = 1'b1;
                        out_item_next.out_kind   = KIND_ERROR;
                        out_item_next.error_code = ERR_LINE_LONG;
                    end
                    else
                    begin
                        line_count_next        = line_count_inc;
                        out_item_next.out_kind = KIND_BYTE;
                        out_item_next.out_byte = b;
                    end
                end
            end
            else if (field_start_reg && (b == quote_reg))
            begin
                field_start_next = 1'b0;
                in_quotes_next   = 1'b1;
            end
            else if (b == separator_reg)
            begin
                has_result = 1'b1;
                if (line_full)
                begin
                    skip_next                = 1'b1;
                    out_item_next.out_kind   = KIND_ERROR;
                    out_item_next.error_code = ERR_LINE_LONG;
                end
                else if (col_full)
                begin
                    line_count_next          = line_count_inc;
                    skip_next                = 1'b1;
                    out_item_next.out_kind   = KIND_ERROR;
                    out_item_next.error_code = ERR_COLUMNS;
                end
                else
                begin
                    line_count_next        = line_count_inc;
                    field_count_next       = field_count_inc;
                    field_start_next       = 1'b1;
                    out_item_next.out_kind = KIND_FIELD_END;
                end
            end
            else
            begin
                field_start_next = 1'b0;
                has_result       = 1'b1;
                if (line_full)
                begin
                    skip_next                = 1'b1;
                    out_item_next.out_kind   = KIND_ERROR;
                    out_item_next.error_code = ERR_LINE_LONG;
                end
                else
                begin
                    line_count_next        = line_count_inc;
                    out_item_next.out_kind = KIND_BYTE;
                    out_item_next.out_byte = b;
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_item_reg <= item;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= has_result;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_result)
            out_item_reg <= out_item_next;
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg   <= 1'b0;
            quote_pend_reg  <= 1'b0;
            field_start_reg <= 1'b1;
            skip_reg        <= 1'b0;
            line_count_reg  <= '0;
            field_count_reg <= '0;
        end
        else if (fire)
        begin
            in_quotes_reg   <= in_quotes_next;
            quote_pend_reg  <= quote_pend_next;
            field_start_reg <= field_start_next;
            skip_reg        <= skip_next;
            line_count_reg  <= line_count_next;
            field_count_reg <= field_count_next;
        end
    end

    // checks
    a_pend_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
        quote_pend_reg |-> in_quotes_reg)
        else $error("pending quote outside quoted text");

    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.end_of_input |=> line_count_reg == '0 && !skip_reg)
        else $error("end of input left line state behind");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stream_done |->
            result.out_kind == KIND_STREAM_END || result.out_kind == KIND_LINE_END
            || result.out_kind == KIND_ERROR)
        else $error("stream end with wrong kind");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind == KIND_ERROR |-> result.error_code != ERR_NONE)
        else $error("error result without code");

    a_fail_skips: assert property (@(posedge clk) disable iff (!rst_n)
        fire && has_result && out_item_next.out_kind == KIND_ERROR
            && (out_item_next.error_code == ERR_LINE_LONG
                || out_item_next.error_code == ERR_COLUMNS) |=> skip_reg)
        else $error("limit error did not start skipping");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for csv_field_splitter; drives items and apb
// register writes, predicts each result; depends on csvfs_pkg and the rtl

module tb;
    import csvfs_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    // expected result tracker: mirrors the splitter state and registers
    class csv_token_board;
        logic [7:0]                 sep_char;
        logic [7:0]                 quote_char;
        logic [LINE_LIMIT_BITS-1:0] line_limit;
        logic [COL_LIMIT_BITS-1:0]  col_limit;
        bit                         in_quotes;
        bit                         quote_pending;
        bit                         at_field_start;
        bit                         skipping;
        int unsigned                line_bytes;
        int unsigned                fields;
        csv_out_t                   expected_tokens[$];
        int                         mismatches;

        function new();
            sep_char   = SEPARATOR_RST;
            quote_char = QUOTE_RST;
            line_limit = LINE_LIMIT_RST;
            col_limit  = COL_LIMIT_RST;
            mismatches = 0;
            start_line();
        endfunction

        function void start_line();
            in_quotes      = 1'b0;
            quote_pending  = 1'b0;
            at_field_start = 1'b1;
            skipping       = 1'b0;
            line_bytes     = 0;
            fields         = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_SEPARATOR:  sep_char   = val[7:0];
                REG_QUOTE:      quote_char = val[7:0];
                REG_LINE_LIMIT: line_limit = val[LINE_LIMIT_BITS-1:0];
                REG_COL_LIMIT:  col_limit  = val[COL_LIMIT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void push_token(logic [2:0] kind, logic [7:0] data, logic [1:0] code,
                                 logic done);
            csv_out_t t;
            t.out_kind    = kind;
            t.out_byte    = data;
            t.error_code  = code;
            t.stream_done = done;
            expected_tokens.push_back(t);
        endfunction

        function void raise_error(logic [1:0] code);
            skipping = 1'b1;
            push_token(KIND_ERROR, 8'd0, code, 1'b0);
        endfunction

        // counts one stored byte if the line still has room
        function bit room_for_byte();
            if (line_bytes >= line_limit)
                return 1'b0;
            line_bytes++;
            return 1'b1;
        endfunction

        function void store_byte(logic [7:0] b);
            if (!room_for_byte())
                raise_error(ERR_LINE_LONG);
            else
                push_token(KIND_BYTE, b, ERR_NONE, 1'b0);
        endfunction

        // advance on one accepted item; returns 1 if the item was not skipped
        function bit note_item(csv_in_t it);
            logic [7:0] b;
            bit         empty_line;
            b = it.in_byte;
            // end of stream always answers and starts a fresh stream
            if (it.end_of_input)
            begin
                if (in_quotes && !quote_pending && !skipping && line_bytes == 0)
                    push_token(KIND_ERROR, 8'd0, ERR_OPEN_QUOTE, 1'b1);
                else if (skipping || line_bytes == 0)
                    push_token(KIND_STREAM_END, 8'd0, ERR_NONE, 1'b1);
                else if (in_quotes && !quote_pending)
                    push_token(KIND_ERROR, 8'd0, ERR_OPEN_QUOTE, 1'b1);
                else
                    push_token(KIND_LINE_END, 8'd0, ERR_NONE, 1'b1);
                start_line();
                return 1'b1;
            end
            // after an error everything up to the newline is dropped
            if (skipping)
            begin
                if (b == CH_LF)
                    start_line();
                return 1'b0;
            end
            // quote seen inside quotes: doubled quote or end of quoted text
            if (quote_pending)
            begin
                quote_pending = 1'b0;
                if (b == quote_char)
                begin
                    store_byte(b);
                    return 1'b1;
                end
                in_quotes = 1'b0;
            end
            if (b == CH_CR)
                return 1'b1;
            if (b == CH_LF)
            begin
                if (in_quotes)
                begin
                    start_line();
                    push_token(KIND_ERROR, 8'd0, ERR_OPEN_QUOTE, 1'b0);
                    return 1'b1;
                end
                empty_line = (line_bytes == 0);
                start_line();
                push_token(empty_line ? KIND_EMPTY : KIND_LINE_END, 8'd0, ERR_NONE, 1'b0);
                return 1'b1;
            end
            if (in_quotes)
            begin
                if (b == quote_char)
                    quote_pending = 1'b1;
                else
                    store_byte(b);
                return 1'b1;
            end
            if (at_field_start && b == quote_char)
            begin
                at_field_start = 1'b0;
                in_quotes      = 1'b1;
                return 1'b1;
            end
            // separator: length checked before column count
            if (b == sep_char)
            begin
                if (!room_for_byte())
                    raise_error(ERR_LINE_LONG);
                else if (fields + 1 >= col_limit)
                    raise_error(ERR_COLUMNS);
                else
                begin
                    fields++;
                    at_field_start = 1'b1;
                    push_token(KIND_FIELD_END, 8'd0, ERR_NONE, 1'b0);
                end
                return 1'b1;
            end
            at_field_start = 1'b0;
            store_byte(b);
            return 1'b1;
        endfunction

        function void check_result(csv_out_t got);
            csv_out_t want;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: out_kind %0d out_byte %0d error_code %0d",
                       got.out_kind, got.out_byte, got.error_code);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.out_kind !== want.out_kind)
            begin
                $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
                mismatches++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                mismatches++;
            end
            if (got.stream_done !== want.stream_done)
            begin
                $error("stream_done: expected %0d, got %0d", want.stream_done,
                       got.stream_done);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_ready;
    csv_in_t                  item         = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    csv_out_t                 result;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [REG_ADDR_BITS-1:0] paddr        = '0;
    logic [31:0]              pwdata       = '0;
    logic [31:0]              prdata;
    logic                     pready;

    csv_token_board board = new();
    logic [7:0]     text_q[$];
    int             sent_items   = 0;
    bit             send_steady  = 1'b0;
    bit             recv_steady  = 1'b0;
    bit             hold_req     = 1'b0;

    csv_field_splitter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly a text byte that is neither separator, quote nor a line control byte; now and then any byte
    function automatic logic [7:0] content_byte();
        logic [7:0] b;
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, 255));
        do
            b = 8'($urandom_range(32, 126));
        while (b == board.sep_char || b == board.quote_char);
        return b;
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // one record with random content, not always well-formed
    function automatic void make_record();
        int nfields;
        int flen;
        int r;
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                text_q.push_back(CH_CR);
            text_q.push_back(CH_LF);
            return;
        end
        nfields = $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                text_q.push_back(board.sep_char);
            flen = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
            begin
                // quoted field with doubled quotes and separators inside
                text_q.push_back(board.quote_char);
                for (int i = 0; i < flen; i++)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                    begin
                        text_q.push_back(board.quote_char);
                        text_q.push_back(board.quote_char);
                    end
                    else if (r == 1)
                        text_q.push_back(board.sep_char);
                    else
                        text_q.push_back(content_byte());
                end
                text_q.push_back(board.quote_char);
                if ($urandom_range(0, 5) == 0)
                    text_q.push_back(content_byte());
            end
            else
            begin
                for (int i = 0; i < flen; i++)
                    text_q.push_back(content_byte());
            end
        end
        if ($urandom_range(0, 3) == 0)
            text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
    endfunction

    // offer one item, hold it until taken, then maybe pause
    task automatic send_item(input csv_in_t it);
        int gap;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        void'(board.note_item(it));
        sent_items++;
        gap = pick_gap(send_steady);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text();
        csv_in_t it;
        while (text_q.size() > 0)
        begin
            it.in_byte      = text_q.pop_front();
            it.end_of_input = 1'b0;
            send_item(it);
        end
    endtask

    task automatic send_eoi();
        csv_in_t it;
        it.in_byte      = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        send_item(it);
    endtask

    // stop offering and wait for every expected result plus settle time
    task automatic drain();
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic set_config(input logic [7:0] sep, input logic [7:0] quote,
                              input logic [31:0] line_lim, input logic [31:0] col_lim);
        write_reg(REG_SEPARATOR, {24'd0, sep});
        write_reg(REG_QUOTE, {24'd0, quote});
        write_reg(REG_LINE_LIMIT, line_lim);
        write_reg(REG_COL_LIMIT, col_lim);
    endtask

    // random records mixed with noise bursts and end marks
    task automatic run_items(input int n);
        int target;
        int r;
        int k;
        target = sent_items + n;
        while (sent_items < target)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_eoi();
            else if (r < 3)
            begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++)
                    text_q.push_back(8'($urandom_range(0, 255)));
                send_text();
            end
            else
            begin
                make_record();
                send_text();
            end
        end
    endtask

    // result side: random stalls, on request one long hold-off
    initial
    begin
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                board.check_result(result);
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = pick_gap(recv_steady);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        do
            @(posedge clk);
        while (!rst_n);

        // directed: plain fields, doubled quote, crlf, empty quoted field,
        // newline in quotes, quote inside an unquoted field
        add_str("a,b\n");
        add_str("\"x\"\"y\",\n");
        add_str("\r\n");
        add_str("\"\"\n");
        add_str("\"a\n");
        add_str("a\"\n");
        send_text();
        // end mark on an empty line, in open quotes, after extreme bytes
        send_eoi();
        add_str("\"");
        send_text();
        send_eoi();
        text_q.push_back(8'h00);
        text_q.push_back(8'hff);
        send_text();
        send_eoi();
        drain();

        // small limits: long lines and too many columns
        set_config(8'd44, 8'd34, 32'd12, 32'd3);
        run_items(60);
        drain();

        // other characters, widest limits, first with no idling on either side
        set_config(8'd59, 8'd39, 32'd1048575, 32'd65535);
        send_steady = 1'b1;
        recv_steady = 1'b1;
        run_items(40);
        send_steady = 1'b0;
        recv_steady = 1'b0;
        run_items(40);
        drain();

        // receiver holds off while the sender keeps offering
        hold_req    = 1'b1;
        send_steady = 1'b1;
        run_items(40);
        send_steady = 1'b0;
        drain();

        // extreme characters and the tightest nonzero limits
        set_config(8'd0, 8'd255, 32'd1, 32'd1);
        run_items(30);
        drain();

        // zero limits fail every store and every separator
        set_config(8'd255, 8'd0, 32'd0, 32'd0);
        run_items(20);
        drain();

        // separator equal to quote: quote wins at a field start and inside quotes
        set_config(8'd44, 8'd44, 32'd30, 32'd4);
        run_items(20);
        drain();

        // separator and quote on the line control bytes
        set_config(CH_CR, CH_LF, 32'd20, 32'd4);
        run_items(20);
        drain();

        // random settings
        repeat (3)
        begin
            set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom_range(1, 40), $urandom_range(1, 6));
            run_items(30);
            drain();
        end

        // back to reset values
        set_config(SEPARATOR_RST, QUOTE_RST, {12'd0, LINE_LIMIT_RST},
                   {16'd0, COL_LIMIT_RST});
        recv_steady = 1'b1;
        run_items(30);
        recv_steady = 1'b0;
        run_items(30);
        drain();

        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
sv/csvfs_pkg.sv
sv/csv_field_splitter.sv
verif/tb.sv
